FILE: rtl/etok_pkg.sv
`default_nettype none

package etok_pkg;

   typedef enum logic [2:0] {
      TK_NUMBER = 3'd0,
      TK_IDENT  = 3'd1,
      TK_OPER   = 3'd2,
      TK_LPAREN = 3'd3,
      TK_RPAREN = 3'd4,
      TK_COMMA  = 3'd5,
      TK_EOF    = 3'd6,
      TK_EOL    = 3'd7
   } token_kind_type;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_US     = 8'h5F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;

   // token queue depth; one lexed item pushes at most two tokens
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      logic [15:0]    column;
      logic [7:0]     lead;
      logic           last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } lex_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_US};
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return c inside {CH_PLUS, CH_MINUS, CH_EQUAL, CH_STAR, CH_SLASH, CH_CARET};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/expression_tokenizer.sv
`default_nettype none

// Streaming lexer for arithmetic expressions. Each req beat carries one
// character or an end-of-input marker; each rsp beat carries one token
// (number, identifier, operator, paren, comma, end of line, end of file).
// One req beat is taken per cycle while req_stall is low: the character
// sits in an input register, is lexed combinationally and its zero, one or
// two tokens are pushed into a four-entry token queue that drives rsp. A
// character that ends a pending token and is a token itself, or an end of
// input with a token pending, yields two rsp beats, so the sustained rate
// is one req beat per cycle as long as the tokens produced average at most
// one per cycle and rsp is not stalled; req_stall rises when a beat waits
// in the input register and the queue has fewer than two free entries.
// End of input flushes the pending token, emits end of file and returns
// the lexer to its reset state.
module expression_tokenizer
   import etok_pkg::*;
#(
   parameter int unsigned POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_token_kind,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_token_length,
   output logic [15:0]      rsp_scan_column,
   output logic [7:0]       rsp_lead_char,
   output logic             rsp_last_of_run
);

   logic        in_valid_ff, in_valid_in;
   logic        in_type_ff;
   logic [7:0]  in_char_ff;
   logic        room;
   logic        fire;
   logic        accept;
   lex_out_type lex_out;
   token_type   head_tok;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_char_ff <= req_char_code;
      end
   end

   etok_lexer #(
      .POS_BITS (POS_BITS)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_type (in_type_ff),
      .in_char (in_char_ff),
      .lex_out (lex_out)
   );

   etok_tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (lex_out),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_tok   (head_tok)
   );

   assign rsp_token_kind   = head_tok.kind;
   assign rsp_start_offset = head_tok.start;
   assign rsp_token_length = head_tok.length;
   assign rsp_scan_column  = head_tok.column;
   assign rsp_lead_char    = head_tok.lead;
   assign rsp_last_of_run  = head_tok.last;

   a_stalled_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_char_ff) && $stable(in_type_ff))
      else $error("held input beat lost");

endmodule

`default_nettype wire

FILE: rtl/etok_lexer.sv
`default_nettype none

module etok_lexer
   import etok_pkg::*;
#(
   parameter int unsigned POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire logic        in_type,
   input  wire logic [7:0]  in_char,
   output lex_out_type      lex_out
);

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_DOT   = 2'd2,
      MODE_IDENT = 2'd3
   } mode_type;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] scan_ff, scan_in;
   logic [POS_BITS-1:0] pstart_ff, pstart_in;
   logic [POS_BITS-1:0] plen_ff, plen_in;
   logic [7:0]          plead_ff, plead_in;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
      return (x == POS_MAX) ? x : x + POS_ONE;
   endfunction

   always_comb begin
      token_type      pend_tok;
      token_type      new_tok;
      logic           pend_v;
      logic           new_v;
      logic           done;
      token_kind_type kind;
      logic           kind_v;

      mode_in   = mode_ff;
      pos_in    = pos_ff;
      scan_in   = scan_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      plead_in  = plead_ff;
      done      = 1'b0;
      kind      = TK_OPER;
      kind_v    = 1'b0;

      // pending token as it stands before this item
      pend_tok.kind   = (mode_ff == MODE_IDENT) ? TK_IDENT : TK_NUMBER;
      pend_tok.start  = 16'(pstart_ff);
      pend_tok.length = 16'(plen_ff);
      pend_tok.column = 16'(scan_ff);
      pend_tok.lead   = plead_ff;
      pend_tok.last   = 1'b0;
      pend_v          = 1'b0;

      new_tok.kind   = TK_EOF;
      new_tok.start  = 16'(pos_ff);
      new_tok.length = '0;
      new_tok.column = 16'(scan_ff);
      new_tok.lead   = '0;
      new_tok.last   = 1'b1;
      new_v          = 1'b0;

      if (in_type == REQ_END) begin
         // flush pending, emit end of file, return to reset state
         new_v = 1'b1;
         if (mode_ff != MODE_IDLE) begin
            pend_v         = 1'b1;
            new_tok.column = 16'(pos_ff);
         end
         mode_in   = MODE_IDLE;
         pos_in    = '0;
         scan_in   = '0;
         pstart_in = '0;
         plen_in   = '0;
         plead_in  = '0;
      end else begin
         case (mode_ff)
            MODE_NUM, MODE_DOT: begin
               if (is_digit(in_char)) begin
                  plen_in = sat_inc(plen_ff);
                  done    = 1'b1;
               end else if (in_char == CH_DOT && mode_ff == MODE_NUM) begin
                  plen_in = sat_inc(plen_ff);
                  mode_in = MODE_DOT;
                  done    = 1'b1;
               end else if (in_char == CH_F) begin
                  // swallow the suffix
                  pend_v  = 1'b1;
                  mode_in = MODE_IDLE;
                  scan_in = sat_inc(pos_ff);
                  done    = 1'b1;
               end else begin
                  pend_v  = 1'b1;
                  mode_in = MODE_IDLE;
                  scan_in = pos_ff;
               end
            end
            MODE_IDENT: begin
               if (is_letter(in_char)) begin
                  plen_in = sat_inc(plen_ff);
                  done    = 1'b1;
               end else begin
                  pend_v  = 1'b1;
                  mode_in = MODE_IDLE;
                  scan_in = pos_ff;
               end
            end
            default: ;
         endcase

         new_tok.column = 16'(scan_in);

         if (!done) begin
            if (in_char == CH_NL) begin
               new_v          = 1'b1;
               new_tok.kind   = TK_EOL;
               new_tok.start  = 16'(pos_ff);
               scan_in        = sat_inc(pos_ff);
            end else if (is_digit(in_char) || is_letter(in_char)) begin
               mode_in   = is_digit(in_char) ? MODE_NUM : MODE_IDENT;
               pstart_in = pos_ff;
               plen_in   = POS_ONE;
               plead_in  = in_char;
            end else begin
               if (is_oper(in_char)) begin
                  kind   = TK_OPER;
                  kind_v = 1'b1;
               end else if (in_char == CH_LPAREN) begin
                  kind   = TK_LPAREN;
                  kind_v = 1'b1;
               end else if (in_char == CH_RPAREN) begin
                  kind   = TK_RPAREN;
                  kind_v = 1'b1;
               end else if (in_char == CH_COMMA) begin
                  kind   = TK_COMMA;
                  kind_v = 1'b1;
               end
               if (kind_v) begin
                  new_v          = 1'b1;
                  new_tok.kind   = kind;
                  new_tok.start  = 16'(pos_ff);
                  new_tok.length = 16'd1;
                  new_tok.lead   = in_char;
                  scan_in        = sat_inc(pos_ff);
               end
            end
         end
         pos_in = sat_inc(pos_ff);
      end

      // pack emitted tokens in order, flag the final one
      lex_out.tok1 = new_tok;
      if (pend_v) begin
         lex_out.tok0      = pend_tok;
         lex_out.tok0.last = !new_v;
         lex_out.count     = new_v ? 2'd2 : 2'd1;
      end else begin
         lex_out.tok0  = new_tok;
         lex_out.count = new_v ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         scan_ff   <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         plead_ff  <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         scan_ff   <= scan_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         plead_ff  <= plead_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_type == REQ_END |=> mode_ff == MODE_IDLE && pos_ff == '0)
      else $error("end of input did not clear lexer state");

   a_two_needs_pending: assert property (@(posedge clock) disable iff (reset)
      lex_out.count == 2'd2 |-> mode_ff != MODE_IDLE)
      else $error("two tokens without a pending token");

endmodule

`default_nettype wire

FILE: rtl/etok_tok_queue.sv
`default_nettype none

module etok_tok_queue
   import etok_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire lex_out_type push_data,
   output logic             room,
   output logic             out_valid,
   input  wire logic        out_stall,
   output token_type        out_tok
);

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] ROOM_MAX = CNT_BITS'(QUEUE_DEPTH - 2);

   token_type            store_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [1:0]           push_cnt;
   logic                 pop;

   assign room      = count_ff <= ROOM_MAX;
   assign out_valid = count_ff != '0;
   assign out_tok   = store_ff[head_ff];
   assign pop       = out_valid && !out_stall;
   assign push_cnt  = push ? push_data.count : 2'd0;

   always_comb begin
      head_in  = pop ? head_ff + PTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + PTR_BITS'(push_cnt);
      count_in = count_ff + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         store_ff[tail_ff] <= push_data.tok0;
      end
      if (push_cnt == 2'd2) begin
         store_ff[tail_ff + PTR_BITS'(1)] <= push_data.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("token queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> room)
      else $error("push into full token queue");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 2'd0 |=> count_ff == $past(count_ff) - CNT_BITS'(1))
      else $error("queue count lost track of a pop");

endmodule

`default_nettype wire
